### hdl/ytr_pkg.sv
// Package for the YUYV to RGB converter: widths, coefficients and shared types.
package ytr_pkg;

  // Input byte and output channel widths
  localparam int unsigned PIX_W  = 8;
  // Fixed-point fraction bits of the coefficients
  localparam int unsigned FRAC_W = 16;
  // Signed width of a channel sum; holds (255 << 16) plus any chroma term
  localparam int unsigned SUM_W  = 28;

  // Dimming multiplier, applied as (c * DIM_MUL) >> PIX_W
  localparam logic [PIX_W-1:0] DIM_MUL = 8'd220;
  // Largest channel value before dimming
  localparam logic [PIX_W-1:0] CHAN_MAX = 8'd255;
  // Largest channel value after dimming
  localparam logic [PIX_W-1:0] OUT_MAX = 8'd219;

  typedef logic signed [SUM_W-1:0] term_t;

  // Unsigned Q1.16 coefficients, rounded to nearest
  localparam term_t COEF_RV = 28'sd89831;
  localparam term_t COEF_GV = 28'sd45744;
  localparam term_t COEF_GU = 28'sd22127;
  localparam term_t COEF_BU = 28'sd113538;

  // Chroma contributions shared by both pixels of a macropixel
  typedef struct packed {
    term_t rv;  // red term from V
    term_t gc;  // green term from U and V, sign already applied
    term_t bu;  // blue term from U
  } chroma_terms_t;

  // One dimmed RGB pixel
  typedef struct packed {
    logic [PIX_W-1:0] red;
    logic [PIX_W-1:0] green;
    logic [PIX_W-1:0] blue;
  } rgb_t;

endpackage

### hdl/ytr_chroma.sv
// Shared chroma stage: removes the chroma offset and registers the three chroma terms.
module ytr_chroma (
  input  logic                         clk,
  input  logic                         load,
  input  logic [ytr_pkg::PIX_W-1:0]    chroma_blue,
  input  logic [ytr_pkg::PIX_W-1:0]    chroma_red,
  output ytr_pkg::chroma_terms_t       terms
);
  import ytr_pkg::*;

  logic signed [PIX_W-1:0] cb;
  logic signed [PIX_W-1:0] cr;
  term_t                   cb_ext;
  term_t                   cr_ext;
  chroma_terms_t           terms_nxt;
  chroma_terms_t           terms_r;

  // Subtract 128: flip the top bit to get a two's complement byte
  assign cb = {~chroma_blue[PIX_W-1], chroma_blue[PIX_W-2:0]};
  assign cr = {~chroma_red[PIX_W-1], chroma_red[PIX_W-2:0]};
  assign cb_ext = term_t'(cb);
  assign cr_ext = term_t'(cr);

  // Form the constant products
  always_comb begin
    terms_nxt.rv = cr_ext * COEF_RV;
    terms_nxt.gc = term_t'(0) - cr_ext * COEF_GV - cb_ext * COEF_GU;
    terms_nxt.bu = cb_ext * COEF_BU;
  end

  // Hold the terms until the stage advances
  always_ff @(posedge clk) begin
    if (load) begin
      terms_r <= terms_nxt;
    end
  end

  assign terms = terms_r;

endmodule

### hdl/ytr_lane.sv
// Pixel lane: adds luma to the chroma terms, clamps, truncates and dims one pixel.
module ytr_lane (
  input  logic [ytr_pkg::PIX_W-1:0]  luma,
  input  ytr_pkg::chroma_terms_t     terms,
  output ytr_pkg::rgb_t              pixel
);
  import ytr_pkg::*;

  term_t base;

  // Clamp a Q.16 sum to 0..255 and scale by 220/256
  function automatic logic [PIX_W-1:0] finish(input term_t sum);
    logic [PIX_W-1:0]   c;
    logic [2*PIX_W-1:0] prod;
    if (sum[SUM_W-1]) begin
      c = '0;
    end else if (|sum[SUM_W-2:FRAC_W+PIX_W]) begin
      c = CHAN_MAX;
    end else begin
      c = sum[FRAC_W+PIX_W-1:FRAC_W];
    end
    prod = c * DIM_MUL;
    return prod[2*PIX_W-1:PIX_W];
  endfunction

  assign base = term_t'({luma, {FRAC_W{1'b0}}});

  // Combine luma with each chroma term
  always_comb begin
    pixel.red   = finish(base + terms.rv);
    pixel.green = finish(base + terms.gc);
    pixel.blue  = finish(base + terms.bu);
  end

endmodule

### hdl/yuyv_to_rgb_dimmed.sv
// Top level of the YUYV 4:2:2 to dimmed RGB888 converter.
//
//  channel | direction | handshake            | payload
//  --------+-----------+----------------------+----------------------------------------
//  in_     | input     | in_valid / in_ready  | Y0, U, Y1, V bytes and last flag
//  out_    | output    | out_valid / out_ready| two RGB pixels (0..219) and last flag
//
// One macropixel per clock unless out_ready stalls; results pass both stage registers.
// Stage one registers the shared chroma products, stage two merges both pixel lanes
// into the output register. rst_n (synchronous) clears only the stage valid bits.
// A stalled output holds its data; the chroma stage still takes one more transaction.
module yuyv_to_rgb_dimmed (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  logic [ytr_pkg::PIX_W-1:0] in_luma_first,
  input  logic [ytr_pkg::PIX_W-1:0] in_chroma_blue,
  input  logic [ytr_pkg::PIX_W-1:0] in_luma_second,
  input  logic [ytr_pkg::PIX_W-1:0] in_chroma_red,
  input  logic                      in_last_in,
  output logic                      out_valid,
  input  logic                      out_ready,
  output logic [ytr_pkg::PIX_W-1:0] out_red_first,
  output logic [ytr_pkg::PIX_W-1:0] out_green_first,
  output logic [ytr_pkg::PIX_W-1:0] out_blue_first,
  output logic [ytr_pkg::PIX_W-1:0] out_red_second,
  output logic [ytr_pkg::PIX_W-1:0] out_green_second,
  output logic [ytr_pkg::PIX_W-1:0] out_blue_second,
  output logic                      out_last_out
);
  import ytr_pkg::*;

  logic             s1_valid_r;
  logic             s1_valid_nxt;
  logic [PIX_W-1:0] s1_luma0_r;
  logic [PIX_W-1:0] s1_luma1_r;
  logic             s1_last_r;
  chroma_terms_t    s1_terms;

  logic             out_valid_r;
  logic             out_valid_nxt;
  rgb_t             out_pix0_r;
  rgb_t             out_pix1_r;
  logic             out_last_r;
  rgb_t             lane_pix0;
  rgb_t             lane_pix1;

  logic             s2_adv;
  logic             s1_load;

  // Advance a stage when it is empty or its successor takes its content
  assign s2_adv   = !out_valid_r || out_ready;
  assign in_ready = !s1_valid_r || s2_adv;
  assign s1_load  = in_valid && in_ready;

  // Shared chroma products
  ytr_chroma u_chroma (
    .clk         (clk),
    .load        (s1_load),
    .chroma_blue (in_chroma_blue),
    .chroma_red  (in_chroma_red),
    .terms       (s1_terms)
  );

  // Hold luma and last alongside the chroma terms
  always_ff @(posedge clk) begin
    if (s1_load) begin
      s1_luma0_r <= in_luma_first;
      s1_luma1_r <= in_luma_second;
      s1_last_r  <= in_last_in;
    end
  end

  // Two pixel lanes on the shared terms
  ytr_lane u_lane0 (
    .luma  (s1_luma0_r),
    .terms (s1_terms),
    .pixel (lane_pix0)
  );

  ytr_lane u_lane1 (
    .luma  (s1_luma1_r),
    .terms (s1_terms),
    .pixel (lane_pix1)
  );

  // Valid bits for both stages
  always_comb begin
    s1_valid_nxt  = s1_valid_r;
    out_valid_nxt = out_valid_r;
    if (in_ready) begin
      s1_valid_nxt = in_valid;
    end
    if (s2_adv) begin
      out_valid_nxt = s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Merge both lanes into the output register
  always_ff @(posedge clk) begin
    if (s2_adv && s1_valid_r) begin
      out_pix0_r <= lane_pix0;
      out_pix1_r <= lane_pix1;
      out_last_r <= s1_last_r;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_red_first    = out_pix0_r.red;
  assign out_green_first  = out_pix0_r.green;
  assign out_blue_first   = out_pix0_r.blue;
  assign out_red_second   = out_pix1_r.red;
  assign out_green_second = out_pix1_r.green;
  assign out_blue_second  = out_pix1_r.blue;
  assign out_last_out     = out_last_r;

`ifndef ASSERT_OFF
  // Dimmed channels never exceed the scaled maximum
  a_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_red_first <= OUT_MAX) && (out_green_first <= OUT_MAX) &&
                  (out_blue_first <= OUT_MAX) && (out_red_second <= OUT_MAX) &&
                  (out_green_second <= OUT_MAX) && (out_blue_second <= OUT_MAX))
    else $error("output channel above dimmed maximum");

  // A full pipe with a stalled output refuses new transactions
  a_full: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_valid_r && out_valid_r && !out_ready) |-> !in_ready)
    else $error("input taken while pipeline is full");

  // An accepted transaction occupies the chroma stage next cycle
  a_fill: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> s1_valid_r)
    else $error("accepted transaction lost in chroma stage");

  // A loaded chroma stage reaches the output when it advances
  a_move: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_valid_r && s2_adv) |=> out_valid)
    else $error("chroma stage content dropped");
`endif

endmodule

### tb/testbench.sv
// Self-checking testbench for the YUYV 4:2:2 to dimmed RGB888 converter.
`timescale 1ns / 100ps

module testbench;
  import ytr_pkg::*;

  // Q1.16 conversion coefficients and dimming factor
  localparam longint K_RED_V   = 89831;
  localparam longint K_GREEN_V = 45744;
  localparam longint K_GREEN_U = 22127;
  localparam longint K_BLUE_U  = 113538;
  localparam longint CHROMA_MID = 128;
  localparam longint DIM_FACTOR = 220;

  localparam int RANDOM_ITEMS = 700;
  localparam int NUM_PHASES   = 4;
  localparam int STALL_LIMIT  = 2000;
  localparam int DRAIN_CYCLES = 8;

  // One macropixel as driven on the input channel
  typedef struct packed {
    logic [PIX_W-1:0] y0;
    logic [PIX_W-1:0] u;
    logic [PIX_W-1:0] y1;
    logic [PIX_W-1:0] v;
    logic             last;
  } macropixel_t;

  // Two converted pixels plus the frame marker
  typedef struct packed {
    rgb_t px_first;
    rgb_t px_second;
    logic last;
  } rgb_pair_t;

  typedef struct packed {
    macropixel_t mp;
    logic        typed;
    rgb_pair_t   want;
  } dir_row_t;

  localparam rgb_t PX_BLACK = '{8'd0, 8'd0, 8'd0};
  localparam rgb_t PX_FULL  = '{8'd219, 8'd219, 8'd219};

  // Directed rows: typed results only where neutral chroma makes them obvious
  localparam int NUM_DIR = 16;
  localparam dir_row_t DIR_ROWS [NUM_DIR] = '{
    '{'{8'd0,   8'd128, 8'd0,   8'd128, 1'b0}, 1'b1, '{PX_BLACK, PX_BLACK, 1'b0}},
    '{'{8'd255, 8'd128, 8'd255, 8'd128, 1'b1}, 1'b1, '{PX_FULL,  PX_FULL,  1'b1}},
    '{'{8'd255, 8'd128, 8'd0,   8'd128, 1'b0}, 1'b1, '{PX_FULL,  PX_BLACK, 1'b0}},
    '{'{8'd0,   8'd128, 8'd255, 8'd128, 1'b1}, 1'b1, '{PX_BLACK, PX_FULL,  1'b1}},
    '{'{8'd0,   8'd0,   8'd0,   8'd0,   1'b0}, 1'b0, '0},
    '{'{8'd255, 8'd255, 8'd255, 8'd255, 1'b1}, 1'b0, '0},
    '{'{8'd0,   8'd255, 8'd255, 8'd0,   1'b0}, 1'b0, '0},
    '{'{8'd255, 8'd0,   8'd0,   8'd255, 1'b0}, 1'b0, '0},
    '{'{8'd128, 8'd128, 8'd128, 8'd128, 1'b0}, 1'b0, '0},
    '{'{8'h55,  8'hAA,  8'h55,  8'hAA,  1'b0}, 1'b0, '0},
    '{'{8'hAA,  8'h55,  8'hAA,  8'h55,  1'b1}, 1'b0, '0},
    '{'{8'd127, 8'd127, 8'd128, 8'd129, 1'b0}, 1'b0, '0},
    '{'{8'd16,  8'd240, 8'd235, 8'd16,  1'b0}, 1'b0, '0},
    '{'{8'd0,   8'd128, 8'd0,   8'd255, 1'b0}, 1'b0, '0},
    '{'{8'd255, 8'd0,   8'd255, 8'd128, 1'b1}, 1'b0, '0},
    '{'{8'd1,   8'd129, 8'd254, 8'd127, 1'b0}, 1'b0, '0}
  };

  // Per-phase idle and stall percentages: none, sender, receiver, both light
  localparam int SRC_IDLE [NUM_PHASES] = '{0, 77, 0, 6};
  localparam int RCV_STALL [NUM_PHASES] = '{0, 0, 77, 6};

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic [PIX_W-1:0] in_luma_first = '0;
  logic [PIX_W-1:0] in_chroma_blue = '0;
  logic [PIX_W-1:0] in_luma_second = '0;
  logic [PIX_W-1:0] in_chroma_red = '0;
  logic in_last_in = 1'b0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic [PIX_W-1:0] out_red_first;
  logic [PIX_W-1:0] out_green_first;
  logic [PIX_W-1:0] out_blue_first;
  logic [PIX_W-1:0] out_red_second;
  logic [PIX_W-1:0] out_green_second;
  logic [PIX_W-1:0] out_blue_second;
  logic out_last_out;

  // Expected pair for the transaction currently offered on the input
  rgb_pair_t offered_pair = '0;
  rgb_pair_t pair_q[$];
  int err_count = 0;
  int quiet_cycles = 0;
  int src_idle_pct = 0;
  int rcv_stall_pct = 0;

  yuyv_to_rgb_dimmed u_top (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_luma_first    (in_luma_first),
    .in_chroma_blue   (in_chroma_blue),
    .in_luma_second   (in_luma_second),
    .in_chroma_red    (in_chroma_red),
    .in_last_in       (in_last_in),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_red_first    (out_red_first),
    .out_green_first  (out_green_first),
    .out_blue_first   (out_blue_first),
    .out_red_second   (out_red_second),
    .out_green_second (out_green_second),
    .out_blue_second  (out_blue_second),
    .out_last_out     (out_last_out)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Clamp a Q.16 sum to 0..255, then dim by 220/256
  function automatic logic [PIX_W-1:0] dim_channel(longint sum);
    longint c;
    if (sum < 0) return '0;
    c = sum >>> 16;
    if (c > 255) c = 255;
    return PIX_W'((c * DIM_FACTOR) >>> 8);
  endfunction

  function automatic rgb_t convert_pixel(logic [PIX_W-1:0] y, longint cb, longint cr);
    longint base;
    rgb_t px;
    base = longint'(y) * 65536;
    px.red   = dim_channel(base + K_RED_V * cr);
    px.green = dim_channel(base - K_GREEN_V * cr - K_GREEN_U * cb);
    px.blue  = dim_channel(base + K_BLUE_U * cb);
    return px;
  endfunction

  function automatic rgb_pair_t predict_pair(macropixel_t mp);
    longint cb;
    longint cr;
    rgb_pair_t p;
    cb = longint'(mp.u) - CHROMA_MID;
    cr = longint'(mp.v) - CHROMA_MID;
    p.px_first  = convert_pixel(mp.y0, cb, cr);
    p.px_second = convert_pixel(mp.y1, cb, cr);
    p.last      = mp.last;
    return p;
  endfunction

  // Bias toward the range ends and the midpoint now and then
  function automatic logic [PIX_W-1:0] pick_byte();
    case ($urandom_range(9))
      0: return '0;
      1: return '1;
      2: return 8'd128;
      default: return PIX_W'($urandom_range(255));
    endcase
  endfunction

  task automatic report_mismatch(string what);
    $display("mismatch at %0t: %s", $realtime, what);
    err_count++;
  endtask

  task automatic check_field(string name, logic [PIX_W-1:0] got, logic [PIX_W-1:0] want);
    if (got !== want)
      report_mismatch($sformatf("%s got %0d expected %0d", name, got, want));
  endtask

  // Offer one transaction after a random gap and hold it until accepted
  task automatic send_macropixel(macropixel_t mp, rgb_pair_t want);
    while ($urandom_range(99) < src_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid       <= 1'b1;
    in_luma_first  <= mp.y0;
    in_chroma_blue <= mp.u;
    in_luma_second <= mp.y1;
    in_chroma_red  <= mp.v;
    in_last_in     <= mp.last;
    offered_pair   <= want;
    do @(posedge clk); while (!in_ready);
  endtask

  // Stall the result channel at the current phase rate
  always @(posedge clk) begin
    out_ready <= ($urandom_range(99) >= rcv_stall_pct);
  end

  // Queue expectations, compare results, and watch for a hung pipeline
  always @(posedge clk) begin
    rgb_pair_t want;
    if (rst_n) begin
      if (in_valid && in_ready)
        pair_q.push_back(offered_pair);
      if (out_valid && out_ready) begin
        if (pair_q.size() == 0) begin
          report_mismatch("result with no transaction pending");
        end else begin
          want = pair_q.pop_front();
          check_field("red_first", out_red_first, want.px_first.red);
          check_field("green_first", out_green_first, want.px_first.green);
          check_field("blue_first", out_blue_first, want.px_first.blue);
          check_field("red_second", out_red_second, want.px_second.red);
          check_field("green_second", out_green_second, want.px_second.green);
          check_field("blue_second", out_blue_second, want.px_second.blue);
          check_field("last_out", PIX_W'(out_last_out), PIX_W'(want.last));
        end
      end
      if ((in_valid && in_ready) || (out_valid && out_ready))
        quiet_cycles = 0;
      else
        quiet_cycles++;
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("FAIL");
        $finish;
      end
    end
  end

  initial begin
    macropixel_t mp;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed rows, no idling
    for (int i = 0; i < NUM_DIR; i++) begin
      mp = DIR_ROWS[i].mp;
      send_macropixel(mp, DIR_ROWS[i].typed ? DIR_ROWS[i].want : predict_pair(mp));
    end

    // Random macropixels, one share per idling phase
    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      src_idle_pct  = SRC_IDLE[ph];
      rcv_stall_pct = RCV_STALL[ph];
      for (int n = 0; n < RANDOM_ITEMS / NUM_PHASES; n++) begin
        mp.y0   = pick_byte();
        mp.u    = pick_byte();
        mp.y1   = pick_byte();
        mp.v    = pick_byte();
        mp.last = ($urandom_range(15) == 0);
        send_macropixel(mp, predict_pair(mp));
      end
    end
    in_valid <= 1'b0;
    // Let the monitor queue the last accepted transaction first
    @(posedge clk);

    // Drain the pipeline, then keep watching for stray results
    while (pair_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (err_count == 0)
      $display("PASS");
    else
      $display("FAIL");
    $finish;
  end

endmodule
